// ===== rtl/sacr_pkg.sv =====
// shared types, constants and helpers for the set-associative cache tag store
// no dependencies
`default_nettype none

package sacr_pkg;

    // geometry
    localparam int LINE_BITS  = 6;
    localparam int SET_BITS   = 8;
    localparam int WAYS       = 4;
    localparam int ADDR_BITS  = 48;
    localparam int COUNT_BITS = 16;

    localparam int NSETS     = 1 << SET_BITS;
    localparam int TAG_LSB   = LINE_BITS + SET_BITS;
    localparam int TAG_BITS  = ADDR_BITS - TAG_LSB;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RRPV_BITS = 2;
    localparam int TS_BITS   = 32;

    localparam logic [RRPV_BITS-1:0] RRPV_MAX    = 2'd3;
    localparam logic [RRPV_BITS-1:0] RRPV_INSERT = 2'd2;

    // replacement policy codes
    localparam logic [1:0] POL_LRU  = 2'd0;
    localparam logic [1:0] POL_LFU  = 2'd1;
    localparam logic [1:0] POL_RRIP = 2'd2;

    // access kinds
    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_FILL   = 1'b1;

    // register map
    localparam int PADDR_W = 3;
    localparam logic REG_POLICY = 1'b0;

    typedef struct packed {
        logic [TAG_BITS-1:0]   tag;
        logic                  valid;
        logic [TS_BITS-1:0]    touch;
        logic [COUNT_BITS-1:0] count;
        logic [RRPV_BITS-1:0]  rrpv;
    } way_t;

    typedef way_t [WAYS-1:0] row_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        logic [COUNT_BITS-1:0] r;
        r = c;
        if (c != {COUNT_BITS{1'b1}})
        begin
            r = c + 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sacr_ctrl.sv =====
// controller fsm: accepts a beat, sequences read and update, owns output valid
// depends on sacr_pkg
`default_nettype none

module sacr_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output sacr_pkg::cmd_t     cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd.capture    = 1'b0;
        cmd.commit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/sacr_datapath.sv =====
// datapath: set memory, row init flags, hit/victim logic and result registers
// depends on sacr_pkg
`default_nettype none

module sacr_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire sacr_pkg::cmd_t                    cmd,
    input  wire logic [1:0]                        policy,
    input  wire logic                              action,
    input  wire logic [sacr_pkg::ADDR_BITS-1:0]    address,
    input  wire logic [sacr_pkg::TS_BITS-1:0]      timestamp,
    output logic                                   hit,
    output logic                                   writeback_needed,
    output logic [sacr_pkg::ADDR_BITS-1:0]         writeback_address
);

    sacr_pkg::row_t mem [sacr_pkg::NSETS];

    logic [sacr_pkg::NSETS-1:0]         row_init_reg;
    logic                               action_reg;
    logic [sacr_pkg::TAG_BITS-1:0]      tag_reg;
    logic [sacr_pkg::SET_BITS-1:0]      set_reg;
    logic [sacr_pkg::TS_BITS-1:0]       ts_reg;
    sacr_pkg::row_t                     rd_row_reg;
    logic                               rd_init_reg;
    logic                               hit_reg;
    logic                               wb_needed_reg;
    logic [sacr_pkg::ADDR_BITS-1:0]     wb_addr_reg;

    sacr_pkg::row_t                     cur;
    sacr_pkg::row_t                     new_row;
    logic                               res_hit;
    logic                               res_wb;
    logic [sacr_pkg::ADDR_BITS-1:0]     res_addr;
    logic [sacr_pkg::SET_BITS-1:0]      in_set;

    assign in_set = address[sacr_pkg::TAG_LSB-1:sacr_pkg::LINE_BITS];

    // item capture and set read
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg  <= action;
            tag_reg     <= address[sacr_pkg::ADDR_BITS-1:sacr_pkg::TAG_LSB];
            set_reg     <= in_set;
            ts_reg      <= timestamp;
            rd_row_reg  <= mem[in_set];
            rd_init_reg <= row_init_reg[in_set];
        end
    end

    // set write back
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            mem[set_reg] <= new_row;
        end
    end

    // rows never written read as reset contents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_init_reg <= '0;
        end
        else if (cmd.commit)
        begin
            row_init_reg[set_reg] <= 1'b1;
        end
    end

    // hit search, victim choice and row update
    always_comb
    begin
        logic                              hit_any;
        logic [sacr_pkg::WAY_W-1:0]        hit_idx;
        logic                              inv_any;
        logic [sacr_pkg::WAY_W-1:0]        inv_idx;
        logic [sacr_pkg::WAY_W-1:0]        lru_idx;
        logic [sacr_pkg::WAY_W-1:0]        lfu_idx;
        logic [sacr_pkg::WAY_W-1:0]        rr_idx;
        logic [sacr_pkg::WAY_W-1:0]        vic_idx;
        logic [sacr_pkg::WAY_W-1:0]        slot;
        logic [sacr_pkg::COUNT_BITS-1:0]   base_cnt;

        for (int w = 0; w < sacr_pkg::WAYS; w++)
        begin
            if (rd_init_reg)
            begin
                cur[w] = rd_row_reg[w];
            end
            else
            begin
                cur[w].tag   = {sacr_pkg::TAG_BITS{1'b1}};
                cur[w].valid = 1'b0;
                cur[w].touch = '0;
                cur[w].count = '0;
                cur[w].rrpv  = sacr_pkg::RRPV_INSERT;
            end
        end

        hit_any = 1'b0;
        hit_idx = '0;
        inv_any = 1'b0;
        inv_idx = '0;
        for (int w = 0; w < sacr_pkg::WAYS; w++)
        begin
            if (!hit_any && cur[w].valid && cur[w].tag == tag_reg)
            begin
                hit_any = 1'b1;
                hit_idx = sacr_pkg::WAY_W'(w);
            end
            if (!inv_any && !cur[w].valid)
            begin
                inv_any = 1'b1;
                inv_idx = sacr_pkg::WAY_W'(w);
            end
        end

        lru_idx = '0;
        lfu_idx = '0;
        rr_idx  = '0;
        for (int w = 1; w < sacr_pkg::WAYS; w++)
        begin
            if (cur[w].touch < cur[lru_idx].touch)
            begin
                lru_idx = sacr_pkg::WAY_W'(w);
            end
            if (cur[w].count < cur[lfu_idx].count)
            begin
                lfu_idx = sacr_pkg::WAY_W'(w);
            end
            if (cur[w].rrpv > cur[rr_idx].rrpv)
            begin
                rr_idx = sacr_pkg::WAY_W'(w);
            end
        end

        case (policy)
            sacr_pkg::POL_LFU:  vic_idx = lfu_idx;
            sacr_pkg::POL_RRIP: vic_idx = rr_idx;
            default:            vic_idx = lru_idx;
        endcase

        new_row  = cur;
        res_hit  = 1'b0;
        res_wb   = 1'b0;
        res_addr = '0;
        slot     = inv_idx;
        base_cnt = cur[inv_idx].count;

        if (action_reg == sacr_pkg::ACT_LOOKUP)
        begin
            if (hit_any)
            begin
                res_hit                = 1'b1;
                new_row[hit_idx].touch = ts_reg;
                new_row[hit_idx].count = sacr_pkg::sat_inc(cur[hit_idx].count);
                new_row[hit_idx].rrpv  = '0;
            end
        end
        else
        begin
            if (!inv_any)
            begin
                slot     = vic_idx;
                base_cnt = '0;
                res_wb   = 1'b1;
                res_addr = {cur[vic_idx].tag, set_reg, {sacr_pkg::LINE_BITS{1'b0}}};
                if (policy == sacr_pkg::POL_RRIP)
                begin
                    for (int w = 0; w < sacr_pkg::WAYS; w++)
                    begin
                        if (cur[w].rrpv != sacr_pkg::RRPV_MAX)
                        begin
                            new_row[w].rrpv = cur[w].rrpv + 1'b1;
                        end
                    end
                end
            end
            new_row[slot].tag   = tag_reg;
            new_row[slot].valid = 1'b1;
            new_row[slot].touch = ts_reg;
            new_row[slot].count = sacr_pkg::sat_inc(base_cnt);
            new_row[slot].rrpv  = sacr_pkg::RRPV_INSERT;
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit_reg       <= res_hit;
            wb_needed_reg <= res_wb;
            wb_addr_reg   <= res_addr;
        end
    end

    assign hit               = hit_reg;
    assign writeback_needed  = wb_needed_reg;
    assign writeback_address = wb_addr_reg;

endmodule

`default_nettype wire

// ===== rtl/set_assoc_cache_replacement.sv =====
// set-associative cache tag store with lru, lfu and srrip replacement
// a beat is captured and its set row read in idle; exec writes the row back and registers
// the result once the output is free, so a new beat is taken only after that commit
// a new beat is taken while a finished result still waits on the output
// reset clears the policy register and all row init flags; no clearing pass
// depends on sacr_pkg, sacr_ctrl, sacr_datapath
`default_nettype none

module set_assoc_cache_replacement (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [sacr_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           action,
    input  wire logic [sacr_pkg::ADDR_BITS-1:0] address,
    input  wire logic [sacr_pkg::TS_BITS-1:0]   timestamp,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                hit,
    output logic                                writeback_needed,
    output logic [sacr_pkg::ADDR_BITS-1:0]      writeback_address
);

    logic [1:0]      policy_reg;
    sacr_pkg::cmd_t  cmd;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= sacr_pkg::POL_LRU;
        end
        else if (psel && penable && pwrite && paddr[2] == sacr_pkg::REG_POLICY)
        begin
            policy_reg <= pwdata[1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == sacr_pkg::REG_POLICY) ? {30'd0, policy_reg} : 32'd0;

    sacr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    sacr_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .policy            (policy_reg),
        .action            (action),
        .address           (address),
        .timestamp         (timestamp),
        .hit               (hit),
        .writeback_needed  (writeback_needed),
        .writeback_address (writeback_address)
    );

endmodule

`default_nettype wire
